[hw/rtl/nec_ir_pulse_transmitter_assert.svh]
// Assertion macros for the NEC IR transmitter.
// Included by the RTL files that check their own logic; depends on nothing.
`ifndef NEC_IR_PULSE_TRANSMITTER_ASSERT_SVH
`define NEC_IR_PULSE_TRANSMITTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define NEC_IR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nec_ir assertion failed");
`define NEC_IR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nec_ir assertion failed");
`else
`define NEC_IR_ASSERT_NOW(label, clk, rst, ante, cons)
`define NEC_IR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[hw/rtl/nec_ir_pkg.sv]
// Shared types and constants for the NEC IR transmitter.
// No dependencies; used by nec_ir_regs, nec_ir_engine and the top level.
package nec_ir_pkg;

  localparam int CODE_BITS = 32;
  localparam int BL_W      = $clog2(CODE_BITS + 1);
  localparam int LEN_W     = 16;
  localparam int CAR_W     = 8;
  localparam int GAP_W     = 18;
  localparam int ADDR_W    = 5;

  typedef struct packed {
    logic [LEN_W-1:0] header_mark_ticks;
    logic [LEN_W-1:0] header_space_ticks;
    logic [LEN_W-1:0] bit_mark_ticks;
    logic [LEN_W-1:0] one_space_ticks;
    logic [LEN_W-1:0] zero_space_ticks;
    logic [CAR_W-1:0] carrier_high_ticks;
    logic [CAR_W-1:0] carrier_low_ticks;
    logic [GAP_W-1:0] min_gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic ir_level;
    logic busy_res;
    logic frame_done;
    logic refused;
  } res_t;

endpackage

[hw/rtl/nec_ir_regs.sv]
// Configuration register file with APB-style access.
// Depends on nec_ir_pkg.
module nec_ir_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nec_ir_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output nec_ir_pkg::cfg_t             cfg
);

  localparam logic [2:0] REG_HMARK  = 3'd0;
  localparam logic [2:0] REG_HSPACE = 3'd1;
  localparam logic [2:0] REG_BMARK  = 3'd2;
  localparam logic [2:0] REG_ONE    = 3'd3;
  localparam logic [2:0] REG_ZERO   = 3'd4;
  localparam logic [2:0] REG_CHIGH  = 3'd5;
  localparam logic [2:0] REG_CLOW   = 3'd6;
  localparam logic [2:0] REG_GAP    = 3'd7;

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_mark_ticks  <= 16'd9000;
      cfg.header_space_ticks <= 16'd4500;
      cfg.bit_mark_ticks     <= 16'd560;
      cfg.one_space_ticks    <= 16'd1690;
      cfg.zero_space_ticks   <= 16'd560;
      cfg.carrier_high_ticks <= 8'd13;
      cfg.carrier_low_ticks  <= 8'd13;
      cfg.min_gap_ticks      <= 18'd110000;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HMARK:  cfg.header_mark_ticks  <= pwdata[15:0];
        REG_HSPACE: cfg.header_space_ticks <= pwdata[15:0];
        REG_BMARK:  cfg.bit_mark_ticks     <= pwdata[15:0];
        REG_ONE:    cfg.one_space_ticks    <= pwdata[15:0];
        REG_ZERO:   cfg.zero_space_ticks   <= pwdata[15:0];
        REG_CHIGH:  cfg.carrier_high_ticks <= pwdata[7:0];
        REG_CLOW:   cfg.carrier_low_ticks  <= pwdata[7:0];
        REG_GAP:    cfg.min_gap_ticks      <= pwdata[17:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HMARK:  prdata = {16'd0, cfg.header_mark_ticks};
      REG_HSPACE: prdata = {16'd0, cfg.header_space_ticks};
      REG_BMARK:  prdata = {16'd0, cfg.bit_mark_ticks};
      REG_ONE:    prdata = {16'd0, cfg.one_space_ticks};
      REG_ZERO:   prdata = {16'd0, cfg.zero_space_ticks};
      REG_CHIGH:  prdata = {24'd0, cfg.carrier_high_ticks};
      REG_CLOW:   prdata = {24'd0, cfg.carrier_low_ticks};
      REG_GAP:    prdata = {14'd0, cfg.min_gap_ticks};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

[hw/rtl/nec_ir_engine.sv]
// Frame sequencer: phase state, tick counters, carrier and code shifter.
// Depends on nec_ir_pkg and nec_ir_pulse_transmitter_assert.svh.
`include "nec_ir_pulse_transmitter_assert.svh"

module nec_ir_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              req_type,
  input  logic [31:0]       code_word,
  input  nec_ir_pkg::cfg_t  cfg,
  output nec_ir_pkg::res_t  res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_HMARK  = 3'd2;
  localparam logic [2:0] PH_HSPACE = 3'd3;
  localparam logic [2:0] PH_BMARK  = 3'd4;
  localparam logic [2:0] PH_BSPACE = 3'd5;
  localparam logic [2:0] PH_TRAIL  = 3'd6;

  localparam int CB = nec_ir_pkg::CODE_BITS;
  localparam int BW = nec_ir_pkg::BL_W;
  localparam int LW = nec_ir_pkg::LEN_W;
  localparam int CW = nec_ir_pkg::CAR_W;
  localparam int GW = nec_ir_pkg::GAP_W;

  logic [2:0]    phase, phase_next;
  logic [BW-1:0] bits_left, bits_left_next;
  logic [CB-1:0] shift_code, shift_code_next;
  logic [LW-1:0] phase_ticks_left, phase_ticks_left_next;
  logic [CW-1:0] carrier_count, carrier_count_next;
  logic          carrier_high, carrier_high_next;
  logic [GW-1:0] since_last_start, since_last_start_next;

  logic          in_mark;
  logic          mark_next;
  logic [CW-1:0] cc_dec;
  logic [LW-1:0] ptl_dec;
  logic [LW-1:0] bit_mark_len;
  logic [LW-1:0] space_len;
  logic [CW-1:0] chigh_len;
  logic [CW-1:0] clow_len;
  logic          done;
  logic          refused;

  function automatic logic [LW-1:0] len_min1(input logic [LW-1:0] v);
    len_min1 = (v == '0) ? LW'(1) : v;
  endfunction

  function automatic logic [CW-1:0] car_min1(input logic [CW-1:0] v);
    car_min1 = (v == '0) ? CW'(1) : v;
  endfunction

  assign in_mark = (phase == PH_HMARK) || (phase == PH_BMARK) || (phase == PH_TRAIL);
  assign bit_mark_len = len_min1(cfg.bit_mark_ticks);
  assign chigh_len    = car_min1(cfg.carrier_high_ticks);
  assign clow_len     = car_min1(cfg.carrier_low_ticks);
  assign space_len    = shift_code[CB-1] ? len_min1(cfg.one_space_ticks)
                                         : len_min1(cfg.zero_space_ticks);
  assign cc_dec  = (carrier_count != '0) ? carrier_count - CW'(1) : carrier_count;
  assign ptl_dec = (phase_ticks_left != '0) ? phase_ticks_left - LW'(1) : phase_ticks_left;

  always_comb begin
    phase_next            = phase;
    bits_left_next        = bits_left;
    shift_code_next       = shift_code;
    phase_ticks_left_next = phase_ticks_left;
    carrier_count_next    = carrier_count;
    carrier_high_next     = carrier_high;
    since_last_start_next = since_last_start;
    done                  = 1'b0;
    refused               = 1'b0;
    if (req_type) begin
      if (phase != PH_IDLE) begin
        refused = 1'b1;
      end else begin
        shift_code_next = CB'(code_word);
        bits_left_next  = BW'(CB);
        phase_next      = PH_WAIT;
      end
    end else begin
      if (since_last_start != '1) begin
        since_last_start_next = since_last_start + GW'(1);
      end
      unique case (phase)
        PH_IDLE: begin
        end
        PH_WAIT: begin
          if (since_last_start_next >= cfg.min_gap_ticks) begin
            since_last_start_next = '0;
            phase_next            = PH_HMARK;
            phase_ticks_left_next = len_min1(cfg.header_mark_ticks);
            carrier_high_next     = 1'b1;
            carrier_count_next    = chigh_len;
          end
        end
        default: begin
          if (in_mark) begin
            carrier_count_next = cc_dec;
            if (cc_dec == '0) begin
              carrier_high_next  = ~carrier_high;
              carrier_count_next = carrier_high ? clow_len : chigh_len;
            end
          end
          phase_ticks_left_next = ptl_dec;
          if (ptl_dec == '0) begin
            unique case (phase)
              PH_HMARK: begin
                phase_next            = PH_HSPACE;
                phase_ticks_left_next = len_min1(cfg.header_space_ticks);
                carrier_high_next     = 1'b0;
                carrier_count_next    = '0;
              end
              PH_HSPACE, PH_BSPACE: begin
                phase_next            = (bits_left != '0) ? PH_BMARK : PH_TRAIL;
                phase_ticks_left_next = bit_mark_len;
                carrier_high_next     = 1'b1;
                carrier_count_next    = chigh_len;
              end
              PH_BMARK: begin
                phase_next            = PH_BSPACE;
                shift_code_next       = shift_code << 1;
                bits_left_next        = bits_left - BW'(1);
                phase_ticks_left_next = space_len;
                carrier_high_next     = 1'b0;
                carrier_count_next    = '0;
              end
              default: begin
                phase_next            = PH_IDLE;
                phase_ticks_left_next = '0;
                carrier_high_next     = 1'b0;
                carrier_count_next    = '0;
                done                  = 1'b1;
              end
            endcase
          end
        end
      endcase
    end
  end

  assign mark_next = (phase_next == PH_HMARK) || (phase_next == PH_BMARK) ||
                     (phase_next == PH_TRAIL);

  always_comb begin
    res.ir_level   = mark_next & carrier_high_next;
    res.busy_res   = (phase_next != PH_IDLE);
    res.frame_done = done;
    res.refused    = refused;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bits_left        <= '0;
      shift_code       <= '0;
      phase_ticks_left <= '0;
      carrier_count    <= '0;
      carrier_high     <= 1'b0;
      since_last_start <= '0;
    end else if (step) begin
      phase            <= phase_next;
      bits_left        <= bits_left_next;
      shift_code       <= shift_code_next;
      phase_ticks_left <= phase_ticks_left_next;
      carrier_count    <= carrier_count_next;
      carrier_high     <= carrier_high_next;
      since_last_start <= since_last_start_next;
    end
  end

  `NEC_IR_ASSERT_NEXT(a_done_goes_idle, clk, rst, step && res.frame_done, (phase == PH_IDLE) && !carrier_high)
  `NEC_IR_ASSERT_NEXT(a_refuse_no_change, clk, rst, step && res.refused, $stable(phase) && $stable(shift_code) && $stable(bits_left))
  `NEC_IR_ASSERT_NOW(a_timed_phase_len, clk, rst, (phase != PH_IDLE) && (phase != PH_WAIT), phase_ticks_left != '0)
  `NEC_IR_ASSERT_NOW(a_wait_dark, clk, rst, (phase == PH_WAIT) || (phase == PH_IDLE), !carrier_high && (carrier_count == '0))

endmodule

[hw/rtl/nec_ir_pulse_transmitter.sv]
// Top level of the NEC IR transmitter: input register, sequencer, result register.
// Depends on nec_ir_pkg, nec_ir_regs and nec_ir_engine.
//
// Each input transfer is a tick (req_type 0) or a send request (req_type 1) and yields
// exactly one result transfer. One item is taken per clock cycle when the output side
// keeps up; an item passes an input register, is evaluated combinationally against the
// sequencer state and lands in the result register once the output side can take it.
// ir_level is the LED drive after the item; frame timing is counted in ticks only.
// Timing registers are to be written over the APB-style port while idle (the block
// does not enforce this); a zero length or carrier time counts as one tick.
module nec_ir_pulse_transmitter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [31:0]                   code_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ir_level,
  output logic                          busy_res,
  output logic                          frame_done,
  output logic                          refused,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nec_ir_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  nec_ir_pkg::cfg_t cfg;
  nec_ir_pkg::res_t res;

  logic        item_valid;
  logic        item_req;
  logic [31:0] item_code;
  logic        advance;

  assign advance  = item_valid & (~out_valid | out_ready);
  assign in_ready = ~item_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_req  <= req_type;
      item_code <= code_word;
    end
  end

  nec_ir_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nec_ir_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .req_type  (item_req),
    .code_word (item_code),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ir_level   <= res.ir_level;
      busy_res   <= res.busy_res;
      frame_done <= res.frame_done;
      refused    <= res.refused;
    end
  end

endmodule
